### rtl/ssf_pkg.sv
// Shared package of the sector framer: geometry constants, queue command type
// and the nibble-table CRC-16 fold. No dependencies.
package ssf_pkg;

    localparam int SECTOR_BYTES      = 256;
    localparam int SECTORS_PER_TRACK = 16;
    localparam int QUEUE_DEPTH       = 2;

    localparam int OFFS_W  = (SECTOR_BYTES > 1) ? $clog2(SECTOR_BYTES) : 1;
    localparam int SECT_W  = (SECTORS_PER_TRACK > 1) ? $clog2(SECTORS_PER_TRACK) : 1;
    localparam int QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0]  KEY_RESET = 8'hB3;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;

    localparam logic [15:0] NIB_TABLE [16] = '{
        16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
        16'h8408, 16'h9489, 16'hA50A, 16'hB58B, 16'hC60C, 16'hD68D, 16'hE70E, 16'hF78F
    };

    typedef struct packed {
        logic       first;
        logic       last;
        logic       eot;
        logic [7:0] track;
        logic [7:0] sector_id;
        logic [7:0] data;
    } t_cmd;

    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {4'h0, crc[15:4]} ^ NIB_TABLE[crc[3:0] ^ b[3:0]];
        c = {4'h0, c[15:4]} ^ NIB_TABLE[c[3:0] ^ b[7:4]];
        return c;
    endfunction

endpackage

### rtl/ssf_front.sv
// Front end of the sector framer: accepts input bytes, tracks the position in
// the track and classifies each byte into a queue command. Uses ssf_pkg.
module ssf_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  logic [7:0]    i_track,
    input  logic [7:0]    i_data,
    input  logic          i_full,
    output logic          o_push,
    output ssf_pkg::t_cmd o_cmd
);
    import ssf_pkg::*;

    logic [OFFS_W-1:0] r_offs;
    logic [SECT_W-1:0] r_sector;
    logic [OFFS_W-1:0] n_offs;
    logic [SECT_W-1:0] n_sector;
    logic              is_first;
    logic              is_last;
    logic              is_last_sector;

    assign o_ready        = !i_full;
    assign o_push         = i_valid && !i_full;
    assign is_first       = (r_offs == '0);
    assign is_last        = (r_offs == OFFS_W'(SECTOR_BYTES - 1));
    assign is_last_sector = (r_sector == SECT_W'(SECTORS_PER_TRACK - 1));

    always_comb begin
        o_cmd.first     = is_first;
        o_cmd.last      = is_last;
        o_cmd.eot       = is_last && is_last_sector;
        o_cmd.track     = i_track;
        o_cmd.sector_id = 8'(r_sector) + 8'd1;
        o_cmd.data      = i_data;
    end

    always_comb begin
        n_offs   = r_offs;
        n_sector = r_sector;
        if (o_push) begin
            if (is_last) begin
                n_offs   = '0;
                n_sector = is_last_sector ? '0 : r_sector + SECT_W'(1);
            end else begin
                n_offs = r_offs + OFFS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offs   <= '0;
            r_sector <= '0;
        end else begin
            r_offs   <= n_offs;
            r_sector <= n_sector;
        end
    end

endmodule

### rtl/ssf_queue.sv
// Short command queue between front and back of the sector framer.
// Uses ssf_pkg for the command type and depth.
module ssf_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  ssf_pkg::t_cmd i_cmd,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output ssf_pkg::t_cmd o_cmd
);
    import ssf_pkg::*;

    t_cmd              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

endmodule

### rtl/ssf_back.sv
// Back end of the sector framer: sequences header, scrambled data and CRC bytes
// per command, folds the CRC and drives the output register. Uses ssf_pkg.
module ssf_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cfg_valid,
    input  logic [7:0]    i_cfg_data,
    input  logic          i_head_valid,
    input  ssf_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [7:0]    o_byte,
    output logic          o_eos,
    output logic          o_eot,
    output logic          o_last
);
    import ssf_pkg::*;

    localparam logic [2:0] PH_H0   = 3'd0;
    localparam logic [2:0] PH_H1   = 3'd1;
    localparam logic [2:0] PH_TRK  = 3'd2;
    localparam logic [2:0] PH_SEC  = 3'd3;
    localparam logic [2:0] PH_DATA = 3'd4;
    localparam logic [2:0] PH_CRCH = 3'd5;
    localparam logic [2:0] PH_CRCL = 3'd6;

    logic [7:0]  r_key;
    logic        r_started;
    logic [2:0]  r_phase;
    logic [15:0] r_crc;
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_eos;
    logic        r_out_eot;
    logic        r_out_last;

    logic        emit;
    logic [2:0]  cur_phase;
    logic [2:0]  n_phase;
    logic [7:0]  n_byte;
    logic        n_eos;
    logic        n_eot;
    logic        done;
    logic        do_fold;
    logic [7:0]  fold_in;
    logic [15:0] crc_base;
    logic [15:0] n_crc;

    assign emit      = i_head_valid && (!r_out_valid || i_ready);
    assign cur_phase = r_started ? r_phase : (i_head.first ? PH_H0 : PH_DATA);
    assign o_pop     = emit && done;

    always_comb begin
        n_byte  = 8'h00;
        n_eos   = 1'b0;
        n_eot   = 1'b0;
        done    = 1'b0;
        do_fold = 1'b0;
        fold_in = 8'h00;
        n_phase = PH_DATA;
        unique case (cur_phase)
            PH_H0: begin
                do_fold = 1'b1;
                n_phase = PH_H1;
            end
            PH_H1: begin
                do_fold = 1'b1;
                n_phase = PH_TRK;
            end
            PH_TRK: begin
                n_byte  = i_head.track;
                fold_in = i_head.track;
                do_fold = 1'b1;
                n_phase = PH_SEC;
            end
            PH_SEC: begin
                n_byte  = i_head.sector_id;
                fold_in = i_head.sector_id;
                do_fold = 1'b1;
                n_phase = PH_DATA;
            end
            PH_DATA: begin
                n_byte  = i_head.data ^ r_key;
                fold_in = i_head.data;
                do_fold = 1'b1;
                done    = !i_head.last;
                n_phase = PH_CRCH;
            end
            PH_CRCH: begin
                n_byte  = r_crc[15:8];
                n_phase = PH_CRCL;
            end
            PH_CRCL: begin
                n_byte = r_crc[7:0];
                n_eos  = 1'b1;
                n_eot  = i_head.eot;
                done   = 1'b1;
            end
            default: begin
                done = 1'b1;
            end
        endcase
    end

    assign crc_base = (cur_phase == PH_H0) ? CRC_INIT : r_crc;
    assign n_crc    = do_fold ? crc_fold(crc_base, fold_in) : r_crc;

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_crc      <= n_crc;
            r_out_byte <= n_byte;
            r_out_eos  <= n_eos;
            r_out_eot  <= n_eot;
            r_out_last <= done;
            r_phase    <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key       <= KEY_RESET;
            r_started   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_key <= i_cfg_data;
            end
            if (emit) begin
                r_started   <= !done;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid = r_out_valid;
    assign o_byte  = r_out_byte;
    assign o_eos   = r_out_eos;
    assign o_eot   = r_out_eot;
    assign o_last  = r_out_last;

endmodule

### rtl/sap_sector_framer_crc16.sv
// An accepted byte is queued, and its output bytes are then registered.
// Throughput: one output byte per cycle through the single output lane, unless
// stalled; a plain byte gives 1 output byte, the first of a sector 5, the last 3.
// Reset (synchronous, active low): track position to zero, queue and output
// register emptied, scramble key to 0xB3.
module sap_sector_framer_crc16 (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [7:0] track_number, [15:8] data_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [7:0] out_byte
    output logic        o_m_axis_tlast,
    output logic [1:0]  o_m_axis_tuser,   // [0] end_of_sector, [1] end_of_track
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);
    import ssf_pkg::*;

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_cmd push_cmd;
    t_cmd head_cmd;

    assign o_cfg_ready = 1'b1;

    ssf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_track (i_s_axis_tdata[7:0]),
        .i_data  (i_s_axis_tdata[15:8]),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    ssf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (head_valid),
        .o_cmd   (head_cmd)
    );

    ssf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_data   (i_cfg_data),
        .i_head_valid (head_valid),
        .i_head       (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_m_axis_tvalid),
        .i_ready      (i_m_axis_tready),
        .o_byte       (o_m_axis_tdata),
        .o_eos        (o_m_axis_tuser[0]),
        .o_eot        (o_m_axis_tuser[1]),
        .o_last       (o_m_axis_tlast)
    );

endmodule

### rtl/ssf_checker.sv
// Port-level checks of the sector framer, attached to the top level by bind.
// Depends only on the top-level ports.
module ssf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tlast,
    input logic [1:0]  o_m_axis_tuser
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast)
            && $stable(o_m_axis_tuser))
        else $error("output request changed while stalled");

    a_eot_eos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1] |-> o_m_axis_tuser[0])
        else $error("end of track without end of sector");

    a_eos_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |-> o_m_axis_tlast)
        else $error("end of sector not last of run");

    a_reset_clean: assert property (@(posedge i_clk)
        !i_rst_n |=> o_s_axis_tready && !o_m_axis_tvalid)
        else $error("block not empty after reset");

endmodule

bind sap_sector_framer_crc16 ssf_checker u_ssf_checker (.*);

### tb/sap_sector_framer_crc16_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for sap_sector_framer_crc16: drives track bytes and
// key writes, predicts headers, scrambled data and CRC bytes. Uses ssf_pkg.
module sap_sector_framer_crc16_test;
    import ssf_pkg::*;

    localparam int TRACK_BYTES   = SECTOR_BYTES * SECTORS_PER_TRACK;
    localparam int STALL_PCT     = 6;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int REPORT_MAX    = 10;

    typedef struct packed {
        logic [7:0] value;
        logic       eos;
        logic       eot;
        logic       last;
    } t_framed_byte;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_valid   = 1'b0;
    logic [15:0] s_data    = 16'h0000;
    logic        m_ready   = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [7:0]  cfg_data  = 8'h00;
    logic        s_ready;
    logic        m_valid;
    logic [7:0]  m_data;
    logic        m_last;
    logic [1:0]  m_user;
    logic        cfg_ready;

    bit           steady = 1'b0;
    int           byte_pos = 0;
    logic [15:0]  sector_crc = 16'hFFFF;
    logic [7:0]   key = KEY_RESET;
    t_framed_byte pending_bytes[$];
    t_framed_byte want;
    int           mismatches = 0;
    int           idle_cycles = 0;

    sap_sector_framer_crc16 u_dut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .o_m_axis_tlast  (m_last),
        .o_m_axis_tuser  (m_user),
        .i_cfg_valid     (cfg_valid),
        .o_cfg_ready     (cfg_ready),
        .i_cfg_data      (cfg_data)
    );

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(negedge clk) begin
        m_ready <= steady || ($urandom_range(0, 99) >= STALL_PCT);
    end

    function automatic logic [15:0] crc_nibbles(input logic [15:0] c, input logic [7:0] b);
        logic [15:0] r;
        logic [3:0]  idx;
        idx = c[3:0] ^ b[3:0];
        r   = (c >> 4) ^ (16'(idx) * 16'h1081);
        idx = r[3:0] ^ b[7:4];
        r   = (r >> 4) ^ (16'(idx) * 16'h1081);
        return r;
    endfunction

    function automatic t_framed_byte framed(input logic [7:0] v, input logic eos,
                                            input logic eot);
        t_framed_byte f;
        f.value = v;
        f.eos   = eos;
        f.eot   = eot;
        f.last  = 1'b0;
        return f;
    endfunction

    task automatic predict_framing(input logic [7:0] trk, input logic [7:0] data);
        int           sector;
        int           offs;
        int           n;
        logic [7:0]   hdr[4];
        t_framed_byte run[5];
        sector = byte_pos / SECTOR_BYTES;
        offs   = byte_pos % SECTOR_BYTES;
        n      = 0;
        if (offs == 0) begin
            hdr[0] = 8'h00;
            hdr[1] = 8'h00;
            hdr[2] = trk;
            hdr[3] = 8'(sector + 1);
            sector_crc = CRC_INIT;
            for (int i = 0; i < 4; i++) begin
                sector_crc = crc_nibbles(sector_crc, hdr[i]);
                run[n] = framed(hdr[i], 1'b0, 1'b0);
                n++;
            end
        end
        sector_crc = crc_nibbles(sector_crc, data);
        run[n] = framed(data ^ key, 1'b0, 1'b0);
        n++;
        if (offs == SECTOR_BYTES - 1) begin
            run[n] = framed(sector_crc[15:8], 1'b0, 1'b0);
            n++;
            run[n] = framed(sector_crc[7:0], 1'b1, sector == SECTORS_PER_TRACK - 1);
            n++;
        end
        run[n - 1].last = 1'b1;
        for (int i = 0; i < n; i++) begin
            pending_bytes.push_back(run[i]);
        end
        byte_pos = (byte_pos + 1 == TRACK_BYTES) ? 0 : byte_pos + 1;
    endtask

    task automatic send_byte(input logic [7:0] trk, input logic [7:0] data);
        while (!steady && $urandom_range(0, 99) < STALL_PCT) begin
            @(negedge clk);
            s_valid <= 1'b0;
        end
        @(negedge clk);
        s_valid <= 1'b1;
        s_data  <= {data, trk};
        @(posedge clk);
        while (!s_ready) @(posedge clk);
        predict_framing(trk, data);
    endtask

    task automatic settle();
        @(negedge clk);
        s_valid <= 1'b0;
        while (pending_bytes.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key(input logic [7:0] value);
        settle();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        key = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_sector_header();
        send_byte(8'h00, 8'h00);
        send_byte(8'hFF, 8'hFF);
        send_byte(8'hFF, 8'h00);
        send_byte(8'h00, 8'hFF);
        send_byte(8'h5A, 8'hA5);
        send_byte(8'hA5, 8'h5A);
    endtask

    task automatic test_scramble_key();
        write_key(8'h00);
        send_byte(8'h13, 8'hFF);
        send_byte(8'hC3, 8'h00);
        send_byte(8'h7E, 8'h81);
        write_key(8'hFF);
        send_byte(8'h00, 8'h00);
        send_byte(8'hFF, 8'hFF);
        send_byte(8'h80, 8'h01);
        send_byte(8'h01, 8'h80);
        write_key(KEY_RESET);
    endtask

    task automatic test_sector_close();
        logic [7:0] trk;
        trk    = 8'($urandom);
        steady = 1'b1;
        while (byte_pos % SECTOR_BYTES != 0) begin
            send_byte(trk, 8'($urandom));
        end
        steady = 1'b0;
        repeat (4) send_byte(8'($urandom), 8'($urandom));
    endtask

    task automatic test_random_stream();
        logic [7:0] trk;
        for (int phase = 0; phase < 4; phase++) begin
            if (phase == 1) write_key(8'($urandom));
            if (phase == 2) write_key(8'hFF);
            if (phase == 3) write_key(8'($urandom));
            trk = 8'($urandom);
            repeat (55) begin
                if (byte_pos % SECTOR_BYTES == 0) trk = 8'($urandom);
                send_byte(($urandom_range(0, 99) < 20) ? 8'($urandom) : trk,
                          8'($urandom));
            end
        end
    endtask

    always @(posedge clk) begin
        if (rst_n && m_valid && m_ready) begin
            if (pending_bytes.size() == 0) begin
                if (mismatches < REPORT_MAX) begin
                    $display("unexpected output: byte %02h eos %0b eot %0b last %0b",
                             m_data, m_user[0], m_user[1], m_last);
                end
                mismatches++;
            end else begin
                want = pending_bytes.pop_front();
                if (m_data !== want.value || m_user[0] !== want.eos ||
                    m_user[1] !== want.eot || m_last !== want.last) begin
                    if (mismatches < REPORT_MAX) begin
                        $display("mismatch: expected byte %02h eos %0b eot %0b last %0b,",
                                 want.value, want.eos, want.eot, want.last);
                        $display("          got      byte %02h eos %0b eot %0b last %0b",
                                 m_data, m_user[0], m_user[1], m_last);
                    end
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
                $display("FAILURE");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_sector_header();
        test_scramble_key();
        test_sector_close();
        test_random_stream();
        settle();
        repeat (10) @(posedge clk);
        if (mismatches == 0 && pending_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
